// ===== rtl/vpf_pkg.sv =====
// vpf_pkg: shared types and constants for the vector path flattener
// opcode codes, controller states and the command/status structs
// no dependencies
package vpf_pkg;

  localparam int FIELD_W = 32;
  localparam int QW      = 6;
  localparam int LIDX_W  = 3;
  localparam logic [QW-1:0] QUALITY_RST = 6'd16;

  typedef enum logic [3:0] {
    OP_BEGIN  = 4'd0,
    OP_MOVE   = 4'd1,
    OP_LINE   = 4'd2,
    OP_HLINE  = 4'd3,
    OP_VLINE  = 4'd4,
    OP_CUBIC  = 4'd5,
    OP_SMOOTH = 4'd6,
    OP_CLOSE  = 4'd7,
    OP_UNSUP  = 4'd8
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_MUL,
    S_ADD,
    S_SEG,
    S_END
  } state_t;

  // lerp slots of one de casteljau evaluation
  localparam logic [LIDX_W-1:0] L_A = 3'd0;
  localparam logic [LIDX_W-1:0] L_B = 3'd1;
  localparam logic [LIDX_W-1:0] L_C = 3'd2;
  localparam logic [LIDX_W-1:0] L_D = 3'd3;
  localparam logic [LIDX_W-1:0] L_E = 3'd4;
  localparam logic [LIDX_W-1:0] L_F = 3'd5;

  typedef struct packed {
    logic              accept;
    logic              exec;
    logic              div_step;
    logic              div_first;
    logic              mul;
    logic              add;
    logic [LIDX_W-1:0] lidx;
    logic              emit_seg;
    logic              emit_end;
  } cmd_t;

  typedef struct packed {
    logic          need_seg;
    logic          is_curve;
    logic [QW-1:0] q_eff;
  } status_t;

endpackage

// ===== rtl/vector_path_flattener.sv =====
// vector_path_flattener: path points in, fixed-point line segments out
// line, move, hline, vline, close: decoded in S_EXEC, segment loaded into the output register
// cubic end point: step division (2^T / quality), then per segment six x/y lerp pairs
// on two multipliers (S_MUL, S_ADD) and S_SEG, for q segments, plus one end segment (S_END)
// one transaction in flight (in_stall outside S_IDLE); the next is taken while the
// last segment waits
// synchronous active-low reset clears path state and sets quality to 16
module vector_path_flattener #(
  parameter int MAX_QUALITY = 63,
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic               in_relative,
  input  logic               in_first_point,
  input  logic signed [31:0] in_pt_x,
  input  logic signed [31:0] in_pt_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_seg_x0,
  output logic signed [31:0] out_seg_y0,
  output logic signed [31:0] out_seg_x1,
  output logic signed [31:0] out_seg_y1,
  output logic               out_last_segment
);

  vpf_pkg::cmd_t    cmd;
  vpf_pkg::status_t st;

  vpf_ctrl #(.T_FRAC_BITS(T_FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  vpf_dp #(
    .MAX_QUALITY (MAX_QUALITY),
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_opcode        (in_opcode),
    .in_relative      (in_relative),
    .in_first_point   (in_first_point),
    .in_pt_x          (in_pt_x),
    .in_pt_y          (in_pt_y),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment)
  );

endmodule

// ===== rtl/vpf_lerp.sv =====
// vpf_lerp: fixed-point linear interpolation a + round((b - a) * t)
// registered product, then combinational round, shift and add
// depends on nothing but its parameters
module vpf_lerp #(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic        [T_FRAC_BITS:0]  t,
  output logic signed [COORD_BITS-1:0] res
);

  localparam int PW = COORD_BITS + T_FRAC_BITS + 3;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);

  logic signed [COORD_BITS:0]   diff;
  logic signed [PW-1:0]         prod_nxt;
  logic signed [PW-1:0]         prod_r;
  logic signed [COORD_BITS-1:0] a_r;
  logic signed [PW-1:0]         rnd;
  logic signed [PW-1:0]         shf;

  assign diff     = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
  assign prod_nxt = PW'(diff) * $signed(PW'({1'b0, t}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      a_r    <= a;
    end
  end

  assign rnd = prod_r + HALF;
  assign shf = rnd >>> T_FRAC_BITS;
  assign res = a_r + shf[COORD_BITS-1:0];

endmodule

// ===== rtl/vpf_ctrl.sv =====
// vpf_ctrl: controller state machine of the vector path flattener
// sequences decode, step division, lerps and segment output
// depends on vpf_pkg
module vpf_ctrl #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  vpf_pkg::status_t st,
  output vpf_pkg::cmd_t    cmd
);

  localparam int DCW = $clog2(T_FRAC_BITS + 1);

  vpf_pkg::state_t          state_r, state_nxt;
  logic [DCW-1:0]           dcnt_r, dcnt_nxt;
  logic [vpf_pkg::QW-1:0]   k_r, k_nxt;
  logic [vpf_pkg::LIDX_W-1:0] lidx_r, lidx_nxt;
  logic                     ovalid_r, ovalid_nxt;
  logic                     out_free;
  logic                     load_out;

  assign out_free  = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign in_stall  = (state_r != vpf_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= vpf_pkg::S_IDLE;
      dcnt_r   <= '0;
      k_r      <= '0;
      lidx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dcnt_r   <= dcnt_nxt;
      k_r      <= k_nxt;
      lidx_r   <= lidx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    k_nxt     = k_r;
    lidx_nxt  = lidx_r;
    load_out  = 1'b0;
    cmd       = '0;
    cmd.lidx  = lidx_r;
    unique case (state_r)
      vpf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = vpf_pkg::S_EXEC;
        end
      end
      vpf_pkg::S_EXEC: begin
        priority if (st.is_curve) begin
          cmd.exec  = 1'b1;
          dcnt_nxt  = '0;
          state_nxt = vpf_pkg::S_DIV;
        end else if (st.need_seg) begin
          if (out_free) begin
            cmd.exec  = 1'b1;
            load_out  = 1'b1;
            state_nxt = vpf_pkg::S_IDLE;
          end
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = vpf_pkg::S_IDLE;
        end
      end
      vpf_pkg::S_DIV: begin
        // one quotient bit of 2^T / q per cycle
        cmd.div_step  = 1'b1;
        cmd.div_first = (dcnt_r == '0);
        dcnt_nxt      = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(T_FRAC_BITS)) begin
          k_nxt     = '0;
          lidx_nxt  = vpf_pkg::L_A;
          state_nxt = vpf_pkg::S_MUL;
        end
      end
      vpf_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = vpf_pkg::S_ADD;
      end
      vpf_pkg::S_ADD: begin
        cmd.add = 1'b1;
        if (lidx_r == vpf_pkg::L_F) begin
          state_nxt = vpf_pkg::S_SEG;
        end else begin
          lidx_nxt  = lidx_r + 1'b1;
          state_nxt = vpf_pkg::S_MUL;
        end
      end
      vpf_pkg::S_SEG: begin
        if (out_free) begin
          cmd.emit_seg = 1'b1;
          load_out     = 1'b1;
          lidx_nxt     = vpf_pkg::L_A;
          if (k_r == st.q_eff - 1'b1) begin
            state_nxt = vpf_pkg::S_END;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = vpf_pkg::S_MUL;
          end
        end
      end
      vpf_pkg::S_END: begin
        if (out_free) begin
          cmd.emit_end = 1'b1;
          load_out     = 1'b1;
          state_nxt    = vpf_pkg::S_IDLE;
        end
      end
      default: state_nxt = vpf_pkg::S_IDLE;
    endcase
    ovalid_nxt = load_out || (ovalid_r && out_stall);
  end

endmodule

// ===== rtl/vpf_dp.sv =====
// vpf_dp: datapath of the vector path flattener
// path state, control points, curve evaluation registers and output register
// depends on vpf_pkg and vpf_lerp
module vpf_dp #(
  parameter int MAX_QUALITY = 63,
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vpf_pkg::cmd_t                      cmd,
  output vpf_pkg::status_t                   st,
  input  logic                               cfg_wr_en,
  input  logic [vpf_pkg::QW-1:0]             cfg_wr_data,
  input  logic [3:0]                         in_opcode,
  input  logic                               in_relative,
  input  logic                               in_first_point,
  input  logic signed [vpf_pkg::FIELD_W-1:0] in_pt_x,
  input  logic signed [vpf_pkg::FIELD_W-1:0] in_pt_y,
  output logic signed [vpf_pkg::FIELD_W-1:0] out_seg_x0,
  output logic signed [vpf_pkg::FIELD_W-1:0] out_seg_y0,
  output logic signed [vpf_pkg::FIELD_W-1:0] out_seg_x1,
  output logic signed [vpf_pkg::FIELD_W-1:0] out_seg_y1,
  output logic                               out_last_segment
);

  localparam int CB = COORD_BITS;
  localparam int TB = T_FRAC_BITS;
  localparam int QW = vpf_pkg::QW;
  localparam logic [QW-1:0] QMAX = QW'(MAX_QUALITY);

  typedef logic signed [CB-1:0] coord_t;

  logic [QW-1:0]    quality_r;
  logic [QW-1:0]    q_eff;

  vpf_pkg::opcode_t op_r;
  logic             rel_r, first_r;
  coord_t           ix_r, iy_r;

  coord_t cur_x_r, cur_y_r, start_x_r, start_y_r;
  coord_t c0x_r, c0y_r, c1x_r, c1y_r;
  logic [1:0] pend_r;
  logic       prev_r;

  coord_t p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r, ex_r, ey_r, fx_r, fy_r;
  coord_t px_r, py_r;

  logic [TB:0]   t_r, quo_r;
  logic [QW-1:0] rem_r, r_r;
  logic [QW:0]   rem_sh, r_sum;
  logic          rem_ge, r_ge;

  coord_t ox0_r, oy0_r, ox1_r, oy1_r;
  logic   olast_r;

  coord_t     tx, ty;
  logic [1:0] pend_eff;
  logic       is_cubic_op;
  logic       need_seg, is_curve;
  coord_t     sx1, sy1;

  coord_t la_x, lb_x, la_y, lb_y, lres_x, lres_y;

  // quality: zero means one, large values saturate
  always_comb begin
    priority if (quality_r == '0) q_eff = QW'(1);
    else if (quality_r > QMAX)   q_eff = QMAX;
    else                         q_eff = quality_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_r <= vpf_pkg::QUALITY_RST;
    end else if (cfg_wr_en) begin
      quality_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= vpf_pkg::opcode_t'(in_opcode);
      rel_r   <= in_relative;
      first_r <= in_first_point;
      ix_r    <= CB'(in_pt_x);
      iy_r    <= CB'(in_pt_y);
    end
  end

  // decode of the held transaction
  always_comb begin
    tx          = rel_r ? cur_x_r + ix_r : ix_r;
    ty          = rel_r ? cur_y_r + iy_r : iy_r;
    is_cubic_op = (op_r == vpf_pkg::OP_CUBIC) || (op_r == vpf_pkg::OP_SMOOTH);
    pend_eff    = (first_r || !is_cubic_op) ? 2'd0 : pend_r;
    need_seg    = 1'b0;
    is_curve    = 1'b0;
    sx1         = tx;
    sy1         = ty;
    unique case (op_r)
      vpf_pkg::OP_MOVE:   need_seg = !first_r;
      vpf_pkg::OP_LINE:   need_seg = 1'b1;
      vpf_pkg::OP_HLINE: begin
        need_seg = 1'b1;
        sy1      = cur_y_r;
      end
      vpf_pkg::OP_VLINE: begin
        need_seg = 1'b1;
        sx1      = cur_x_r;
      end
      vpf_pkg::OP_CLOSE: begin
        need_seg = 1'b1;
        sx1      = start_x_r;
        sy1      = start_y_r;
      end
      vpf_pkg::OP_CUBIC:  is_curve = (pend_eff == 2'd2);
      vpf_pkg::OP_SMOOTH: is_curve = prev_r && (pend_eff != 2'd0);
      default: ;
    endcase
  end

  assign st.need_seg = need_seg;
  assign st.is_curve = is_curve;
  assign st.q_eff    = q_eff;

  // path state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      pend_r    <= '0;
      prev_r    <= 1'b0;
    end else if (cmd.exec) begin
      pend_r <= 2'd0;
      prev_r <= (op_r == vpf_pkg::OP_CUBIC) || ((op_r == vpf_pkg::OP_SMOOTH) && prev_r);
      unique case (op_r)
        vpf_pkg::OP_BEGIN: begin
          cur_x_r   <= '0;
          cur_y_r   <= '0;
          start_x_r <= '0;
          start_y_r <= '0;
        end
        vpf_pkg::OP_MOVE: begin
          if (first_r) begin
            start_x_r <= tx;
            start_y_r <= ty;
          end
          cur_x_r <= tx;
          cur_y_r <= ty;
        end
        vpf_pkg::OP_LINE: begin
          cur_x_r <= tx;
          cur_y_r <= ty;
        end
        vpf_pkg::OP_HLINE: cur_x_r <= tx;
        vpf_pkg::OP_VLINE: cur_y_r <= ty;
        vpf_pkg::OP_CLOSE: begin
          cur_x_r <= start_x_r;
          cur_y_r <= start_y_r;
        end
        vpf_pkg::OP_CUBIC: begin
          if (pend_eff != 2'd2) pend_r <= pend_eff + 2'd1;
        end
        vpf_pkg::OP_SMOOTH: begin
          if (prev_r && pend_eff == 2'd0) pend_r <= 2'd1;
        end
        default: ;
      endcase
    end else if (cmd.emit_end) begin
      cur_x_r <= p3x_r;
      cur_y_r <= p3y_r;
    end
  end

  // pending control points
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_r == vpf_pkg::OP_CUBIC && pend_eff == 2'd0) begin
        c0x_r <= tx;
        c0y_r <= ty;
      end
      if (op_r == vpf_pkg::OP_CUBIC && pend_eff == 2'd1) begin
        c1x_r <= tx;
        c1y_r <= ty;
      end
      if (op_r == vpf_pkg::OP_SMOOTH && prev_r && pend_eff == 2'd0) begin
        c0x_r <= tx;
        c0y_r <= ty;
      end
    end
  end

  // step division and parameter accumulation
  assign rem_sh = {rem_r, cmd.div_first};
  assign rem_ge = rem_sh >= {1'b0, q_eff};
  assign r_sum  = {1'b0, r_r} + {1'b0, rem_r};
  assign r_ge   = r_sum >= {1'b0, q_eff};

  always_ff @(posedge clk) begin
    if (cmd.exec && is_curve) begin
      p0x_r <= cur_x_r;
      p0y_r <= cur_y_r;
      px_r  <= cur_x_r;
      py_r  <= cur_y_r;
      p3x_r <= tx;
      p3y_r <= ty;
      if (op_r == vpf_pkg::OP_CUBIC) begin
        p1x_r <= c0x_r;
        p1y_r <= c0y_r;
        p2x_r <= c1x_r;
        p2y_r <= c1y_r;
      end else begin
        p1x_r <= cur_x_r;
        p1y_r <= cur_y_r;
        p2x_r <= c0x_r;
        p2y_r <= c0y_r;
      end
      t_r   <= '0;
      r_r   <= q_eff >> 1;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? QW'(rem_sh - {1'b0, q_eff}) : rem_sh[QW-1:0];
      quo_r <= {quo_r[TB-1:0], rem_ge};
    end else if (cmd.emit_seg) begin
      px_r <= fx_r;
      py_r <= fy_r;
      if (r_ge) begin
        r_r <= QW'(r_sum - {1'b0, q_eff});
        t_r <= t_r + quo_r + 1'b1;
      end else begin
        r_r <= r_sum[QW-1:0];
        t_r <= t_r + quo_r;
      end
    end
  end

  // lerp operand selection
  always_comb begin
    unique case (cmd.lidx)
      vpf_pkg::L_A: begin la_x = p0x_r; lb_x = p1x_r; la_y = p0y_r; lb_y = p1y_r; end
      vpf_pkg::L_B: begin la_x = p1x_r; lb_x = p2x_r; la_y = p1y_r; lb_y = p2y_r; end
      vpf_pkg::L_C: begin la_x = p2x_r; lb_x = p3x_r; la_y = p2y_r; lb_y = p3y_r; end
      vpf_pkg::L_D: begin la_x = ax_r;  lb_x = bx_r;  la_y = ay_r;  lb_y = by_r;  end
      vpf_pkg::L_E: begin la_x = bx_r;  lb_x = cx_r;  la_y = by_r;  lb_y = cy_r;  end
      default:      begin la_x = dx_r;  lb_x = ex_r;  la_y = dy_r;  lb_y = ey_r;  end
    endcase
  end

  vpf_lerp #(.COORD_BITS(CB), .T_FRAC_BITS(TB)) u_lerp_x (
    .clk (clk),
    .en  (cmd.mul),
    .a   (la_x),
    .b   (lb_x),
    .t   (t_r),
    .res (lres_x)
  );

  vpf_lerp #(.COORD_BITS(CB), .T_FRAC_BITS(TB)) u_lerp_y (
    .clk (clk),
    .en  (cmd.mul),
    .a   (la_y),
    .b   (lb_y),
    .t   (t_r),
    .res (lres_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      unique case (cmd.lidx)
        vpf_pkg::L_A: begin ax_r <= lres_x; ay_r <= lres_y; end
        vpf_pkg::L_B: begin bx_r <= lres_x; by_r <= lres_y; end
        vpf_pkg::L_C: begin cx_r <= lres_x; cy_r <= lres_y; end
        vpf_pkg::L_D: begin dx_r <= lres_x; dy_r <= lres_y; end
        vpf_pkg::L_E: begin ex_r <= lres_x; ey_r <= lres_y; end
        default:      begin fx_r <= lres_x; fy_r <= lres_y; end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.exec && need_seg) begin
      ox0_r   <= cur_x_r;
      oy0_r   <= cur_y_r;
      ox1_r   <= sx1;
      oy1_r   <= sy1;
      olast_r <= 1'b1;
    end else if (cmd.emit_seg) begin
      ox0_r   <= px_r;
      oy0_r   <= py_r;
      ox1_r   <= fx_r;
      oy1_r   <= fy_r;
      olast_r <= 1'b0;
    end else if (cmd.emit_end) begin
      ox0_r   <= px_r;
      oy0_r   <= py_r;
      ox1_r   <= p3x_r;
      oy1_r   <= p3y_r;
      olast_r <= 1'b1;
    end
  end

  assign out_seg_x0       = vpf_pkg::FIELD_W'(ox0_r);
  assign out_seg_y0       = vpf_pkg::FIELD_W'(oy0_r);
  assign out_seg_x1       = vpf_pkg::FIELD_W'(ox1_r);
  assign out_seg_y1       = vpf_pkg::FIELD_W'(oy1_r);
  assign out_last_segment = olast_r;

endmodule
